@@ rtl/hsbp_pkg.sv @@
`default_nettype none
package hsbp_pkg;

    // command codes
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_ENCODE = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;

    localparam int CODE_W   = 32;
    localparam int LEN_W    = 6;
    localparam int SYM_W    = 8;
    localparam int TAIL_W   = 3;
    localparam int WORD_W   = 32;
    localparam int BYTE_W   = 8;

    localparam int DEF_MAX_CODE_LEN = 32;
    localparam int DEF_SYMBOL_COUNT = 256;

    // front-to-back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // one classified operation for the packer
    typedef struct packed {
        logic                flush;
        logic [CODE_W-1:0]   code;
        logic [LEN_W-1:0]    len;
    } t_op;

endpackage
`default_nettype wire

@@ rtl/huffman_symbol_bit_packer.sv @@
// Huffman encoder back end: code table plus bit packer.
// Input channel (i_valid / o_stall): one request per cycle carries a command.
//   Load writes a symbol's code and length into the table (no output).
//   Encode appends the symbol's code to the bit buffer; when more than 32 bits
//   are held, the oldest 32 leave as one word, first bit in bit 0.
//   Flush emits the held bits as zero-padded bytes; the final byte has o_last
//   set and o_tail_bits = held bit count mod 8.
// Output channel (o_valid / i_stall): one word or byte per transfer.
// Throughput: one request per cycle while o_stall is low; a flush of n bytes
// (n <= 4) occupies the packer, while the two-entry queue absorbs new requests.
// Path: a word from an encode request passes the table read register, then the
// queue, then the packer's output register before it appears on the output.
// Reset (synchronous, i_rst_n low) empties buffer and queue and marks every
// table entry unloaded, so such symbols encode to nothing; no clearing pass.
// When the receiver stalls, the output register holds its result; the queue
// fills and then o_stall rises, so no request or result is ever dropped.
`default_nettype none
module huffman_symbol_bit_packer #(
    parameter int MAX_CODE_LEN = hsbp_pkg::DEF_MAX_CODE_LEN,
    parameter int SYMBOL_COUNT = hsbp_pkg::DEF_SYMBOL_COUNT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [1:0]                    i_command,
    input  wire logic [hsbp_pkg::SYM_W-1:0]    i_symbol,
    input  wire logic [hsbp_pkg::CODE_W-1:0]   i_code_bits,
    input  wire logic [hsbp_pkg::LEN_W-1:0]    i_code_length,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [hsbp_pkg::WORD_W-1:0]        o_packed_data,
    output logic                               o_is_byte,
    output logic                               o_last,
    output logic [hsbp_pkg::TAIL_W-1:0]        o_tail_bits
);
    logic           w_push, w_full, w_nempty, w_pop;
    hsbp_pkg::t_op  w_in_op, w_head_op;

    // front: table lookup and classification
    hsbp_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_symbol      (i_symbol),
        .i_code_bits   (i_code_bits),
        .i_code_length (i_code_length),
        .o_push        (w_push),
        .o_op          (w_in_op),
        .i_q_full      (w_full)
    );

    // decoupling queue
    hsbp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_op     (w_in_op),
        .o_full   (w_full),
        .o_nempty (w_nempty),
        .i_pop    (w_pop),
        .o_op     (w_head_op)
    );

    // back: bit packer and output register
    hsbp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_nempty      (w_nempty),
        .i_op          (w_head_op),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_packed_data (o_packed_data),
        .o_is_byte     (o_is_byte),
        .o_last        (o_last),
        .o_tail_bits   (o_tail_bits)
    );

endmodule
`default_nettype wire

@@ rtl/hsbp_front.sv @@
`default_nettype none
module hsbp_front #(
    parameter int MAX_CODE_LEN = hsbp_pkg::DEF_MAX_CODE_LEN,
    parameter int SYMBOL_COUNT = hsbp_pkg::DEF_SYMBOL_COUNT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [1:0]                    i_command,
    input  wire logic [hsbp_pkg::SYM_W-1:0]    i_symbol,
    input  wire logic [hsbp_pkg::CODE_W-1:0]   i_code_bits,
    input  wire logic [hsbp_pkg::LEN_W-1:0]    i_code_length,
    output logic                               o_push,
    output hsbp_pkg::t_op                      o_op,
    input  wire logic                          i_q_full
);
    localparam int AW = $clog2(SYMBOL_COUNT);
    localparam int EW = MAX_CODE_LEN + hsbp_pkg::LEN_W;

    logic [EW-1:0]           r_tab [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] r_tvld;
    logic [EW-1:0]           r_rd;
    logic                    r_rd_vld;

    logic r_s1_vld, r_s1_enc, r_s1_flush;

    logic                        w_acc, w_in_range, w_wr, w_adv, w_keep;
    logic [AW-1:0]               w_addr;
    logic [hsbp_pkg::LEN_W-1:0]  w_len_sat, w_rd_len;
    logic [MAX_CODE_LEN-1:0]     w_mask, w_rd_code;

    assign o_stall    = r_s1_vld && i_q_full;
    assign w_acc      = i_valid && !o_stall;
    assign w_in_range = {1'b0, i_symbol} < (hsbp_pkg::SYM_W+1)'(SYMBOL_COUNT);
    assign w_addr     = i_symbol[AW-1:0];
    assign w_wr       = w_acc && (i_command == hsbp_pkg::CMD_LOAD) && w_in_range;
    assign w_adv      = !r_s1_vld || !i_q_full;

    // saturate length, clear stray bits above it
    always_comb begin
        w_len_sat = (i_code_length > hsbp_pkg::LEN_W'(MAX_CODE_LEN))
                  ? hsbp_pkg::LEN_W'(MAX_CODE_LEN) : i_code_length;
        for (int i = 0; i < MAX_CODE_LEN; i++) begin
            w_mask[i] = (hsbp_pkg::LEN_W'(i) < w_len_sat);
        end
    end

    // table storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_tab[w_addr] <= {w_len_sat, i_code_bits[MAX_CODE_LEN-1:0] & w_mask};
        end
        if (w_acc) begin
            r_rd <= r_tab[w_addr];
        end
    end

    // per-entry valid bits: unloaded entries read as zero length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvld   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (w_wr) begin
                r_tvld[w_addr] <= 1'b1;
            end
            if (w_acc) begin
                r_rd_vld <= r_tvld[w_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_s1_enc   <= 1'b0;
            r_s1_flush <= 1'b0;
        end else if (w_acc) begin
            r_s1_vld   <= 1'b1;
            r_s1_enc   <= (i_command == hsbp_pkg::CMD_ENCODE) && w_in_range;
            r_s1_flush <= (i_command == hsbp_pkg::CMD_FLUSH);
        end else if (w_adv) begin
            r_s1_vld   <= 1'b0;
        end
    end

    assign w_rd_len  = r_rd_vld ? r_rd[EW-1:MAX_CODE_LEN] : '0;
    assign w_rd_code = r_rd_vld ? r_rd[MAX_CODE_LEN-1:0] : '0;
    assign w_keep    = r_s1_flush || (r_s1_enc && (w_rd_len != '0));

    assign o_push     = r_s1_vld && w_keep && !i_q_full;
    assign o_op.flush = r_s1_flush;
    assign o_op.code  = hsbp_pkg::CODE_W'(w_rd_code);
    assign o_op.len   = w_rd_len;

endmodule
`default_nettype wire

@@ rtl/hsbp_queue.sv @@
`default_nettype none
module hsbp_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire hsbp_pkg::t_op   i_op,
    output logic                 o_full,
    output logic                 o_nempty,
    input  wire logic            i_pop,
    output hsbp_pkg::t_op        o_op
);
    hsbp_pkg::t_op                r_slot [hsbp_pkg::QUEUE_DEPTH];
    logic [hsbp_pkg::QPTR_W-1:0]  r_wp, r_rp;
    logic [hsbp_pkg::QCNT_W-1:0]  r_cnt;
    logic                         w_do_pop;

    assign o_full   = (r_cnt == hsbp_pkg::QCNT_W'(hsbp_pkg::QUEUE_DEPTH));
    assign o_nempty = (r_cnt != '0);
    assign o_op     = r_slot[r_rp];
    assign w_do_pop = i_pop && o_nempty;

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_slot[r_wp] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if ((i_push && !o_full) && !w_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!(i_push && !o_full) && w_do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

endmodule
`default_nettype wire

@@ rtl/hsbp_back.sv @@
`default_nettype none
module hsbp_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_nempty,
    input  wire hsbp_pkg::t_op                 i_op,
    output logic                               o_pop,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [hsbp_pkg::WORD_W-1:0]        o_packed_data,
    output logic                               o_is_byte,
    output logic                               o_last,
    output logic [hsbp_pkg::TAIL_W-1:0]        o_tail_bits
);
    localparam int WW = hsbp_pkg::WORD_W;

    logic [WW-1:0]               r_buf;
    logic [hsbp_pkg::LEN_W-1:0]  r_cnt;

    logic                        w_slot, w_emit, w_last_byte, w_fire;
    logic [2*WW-1:0]             w_wide;
    logic [hsbp_pkg::LEN_W:0]    w_sum;

    assign w_slot      = !o_valid || !i_stall;
    assign w_wide      = {{WW{1'b0}}, r_buf} | ({{WW{1'b0}}, i_op.code} << r_cnt);
    assign w_sum       = {1'b0, r_cnt} + {1'b0, i_op.len};
    assign w_emit      = w_sum > (hsbp_pkg::LEN_W+1)'(WW);
    assign w_last_byte = r_cnt <= hsbp_pkg::LEN_W'(hsbp_pkg::BYTE_W);

    // fire: op produces an output this cycle
    always_comb begin
        o_pop  = 1'b0;
        w_fire = 1'b0;
        if (i_nempty) begin
            if (i_op.flush) begin
                if (r_cnt == '0) begin
                    o_pop = 1'b1;
                end else if (w_slot) begin
                    w_fire = 1'b1;
                    o_pop  = w_last_byte;
                end
            end else if (!w_emit || w_slot) begin
                o_pop  = 1'b1;
                w_fire = w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf <= '0;
            r_cnt <= '0;
        end else if (i_nempty) begin
            if (i_op.flush) begin
                if (w_fire) begin
                    r_buf <= w_last_byte ? '0 : (r_buf >> hsbp_pkg::BYTE_W);
                    r_cnt <= w_last_byte ? '0 : (r_cnt - hsbp_pkg::LEN_W'(hsbp_pkg::BYTE_W));
                end
            end else if (o_pop) begin
                r_buf <= w_emit ? w_wide[2*WW-1:WW] : w_wide[WW-1:0];
                r_cnt <= w_emit ? hsbp_pkg::LEN_W'(w_sum - (hsbp_pkg::LEN_W+1)'(WW))
                                : hsbp_pkg::LEN_W'(w_sum);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_fire) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            if (i_op.flush) begin
                o_packed_data <= WW'(r_buf[hsbp_pkg::BYTE_W-1:0]);
                o_is_byte     <= 1'b1;
                o_last        <= w_last_byte;
                o_tail_bits   <= w_last_byte ? r_cnt[hsbp_pkg::TAIL_W-1:0] : '0;
            end else begin
                o_packed_data <= w_wide[WW-1:0];
                o_is_byte     <= 1'b0;
                o_last        <= 1'b0;
                o_tail_bits   <= '0;
            end
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= hsbp_pkg::LEN_W'(WW))
        else $error("bit count above word width");

    a_last_is_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> o_is_byte)
        else $error("last flag on a word");

    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && i_op.flush && w_last_byte) |=> (r_cnt == '0))
        else $error("buffer not empty after flush");

endmodule
`default_nettype wire

@@ bench/tb_huffman_symbol_bit_packer.sv @@
`timescale 1ns / 1ps

module tb_huffman_symbol_bit_packer;

    // command 3 has no meaning; the block must drop it silently
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int MAX_LEN     = 32;
    localparam int SYM_COUNT   = 256;
    localparam int RAND_ITEMS  = 383;
    localparam int DRAIN_AT    = 300;   // random item after which the sender drains
    localparam int HOLD_AFTER  = 120;   // requests taken before the long receiver hold
    localparam int HOLD_CYCLES = 80;
    localparam int QUIET_LIMIT = 4000;  // cycles with no transfer on either side
    localparam int TAIL_WAIT   = 8;

    // one input request, field for field as on the ports
    typedef struct packed {
        logic [1:0]                  cmd;
        logic [hsbp_pkg::SYM_W-1:0]  sym;
        logic [hsbp_pkg::CODE_W-1:0] bits;
        logic [hsbp_pkg::LEN_W-1:0]  len;
    } t_req;

    // one emitted word or flushed byte
    typedef struct packed {
        logic [hsbp_pkg::WORD_W-1:0] data;
        logic                        is_byte;
        logic                        last;
        logic [hsbp_pkg::TAIL_W-1:0] tail;
    } t_packed;

    // directed stimulus row; a typed row carries its result written out by hand
    typedef struct {
        t_req    req;
        bit      typed;
        bit      has_res;
        t_packed res;
    } t_row;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic [1:0]                  i_command;
    logic [hsbp_pkg::SYM_W-1:0]  i_symbol;
    logic [hsbp_pkg::CODE_W-1:0] i_code_bits;
    logic [hsbp_pkg::LEN_W-1:0]  i_code_length;
    logic                        o_valid;
    logic                        i_stall;
    logic [hsbp_pkg::WORD_W-1:0] o_packed_data;
    logic                        o_is_byte;
    logic                        o_last;
    logic [hsbp_pkg::TAIL_W-1:0] o_tail_bits;

    huffman_symbol_bit_packer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_symbol      (i_symbol),
        .i_code_bits   (i_code_bits),
        .i_code_length (i_code_length),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_packed_data (o_packed_data),
        .o_is_byte     (o_is_byte),
        .o_last        (o_last),
        .o_tail_bits   (o_tail_bits)
    );

    // Packer shadow: code table, bit buffer (bit 0 oldest) and held count
    logic [hsbp_pkg::CODE_W-1:0] code_mem [SYM_COUNT];
    logic [hsbp_pkg::LEN_W-1:0]  len_mem  [SYM_COUNT];
    logic [63:0]                 bitbuf;
    int unsigned                 held;

    t_packed packed_new [$];   // results of the request just taken
    t_packed packed_due [$];   // results owed by the block, oldest first
    t_row    dir_rows   [$];

    int mismatch_cnt;
    int n_taken;
    bit held_off;
    int stall_mode;
    int phase_left;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Work out what one accepted request emits and update the shadow state.
    function automatic void advance_packer(input t_req r);
        int unsigned clen;
        int unsigned nbytes;
        int unsigned i;
        logic [63:0] mask;
        t_packed     p;
        packed_new.delete();
        case (r.cmd)
            hsbp_pkg::CMD_LOAD: begin
                if (r.sym < SYM_COUNT) begin
                    // long lengths saturate, bits above the length are dropped
                    clen = (r.len > MAX_LEN) ? MAX_LEN : r.len;
                    mask = (64'd1 << clen) - 64'd1;
                    code_mem[r.sym] = r.bits & mask[hsbp_pkg::CODE_W-1:0];
                    len_mem[r.sym]  = clen[hsbp_pkg::LEN_W-1:0];
                end
            end
            hsbp_pkg::CMD_ENCODE: begin
                // an unloaded (zero-length) symbol appends nothing
                if (r.sym < SYM_COUNT && len_mem[r.sym] != 0 && held <= 32) begin
                    bitbuf = bitbuf | ({32'd0, code_mem[r.sym]} << held);
                    held   = held + len_mem[r.sym];
                    // exactly 32 held stays put; only overflow pushes a word out
                    if (held > 32) begin
                        p = '{data: bitbuf[31:0], is_byte: 1'b0, last: 1'b0, tail: '0};
                        packed_new.push_back(p);
                        bitbuf = bitbuf >> 32;
                        held   = held - 32;
                    end
                end
            end
            hsbp_pkg::CMD_FLUSH: begin
                if (held > 0) begin
                    nbytes = (held + 7) / 8;
                    if (nbytes > 4)
                        nbytes = 4;
                    for (i = 0; i < nbytes; i++) begin
                        p.data    = {24'd0, bitbuf[7:0]};
                        p.is_byte = 1'b1;
                        p.last    = (i + 1 == nbytes);
                        p.tail    = p.last ? held[2:0] : '0;
                        packed_new.push_back(p);
                        bitbuf = bitbuf >> 8;
                    end
                    bitbuf = '0;
                    held   = 0;
                end
            end
            default: ;
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatch_cnt++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    endtask

    task automatic add_row(input logic [1:0] cmd, input int sym, input logic [31:0] bits,
                           input int len, input int typed = 0, input int has_res = 0,
                           input logic [31:0] data = '0, input int last = 0,
                           input int tail = 0, input int is_byte = 1);
        t_row row;
        row.req     = '{cmd: cmd, sym: sym[hsbp_pkg::SYM_W-1:0], bits: bits,
                        len: len[hsbp_pkg::LEN_W-1:0]};
        row.typed   = (typed != 0);
        row.has_res = (has_res != 0);
        row.res     = '{data: data, is_byte: (is_byte != 0), last: (last != 0),
                        tail: tail[hsbp_pkg::TAIL_W-1:0]};
        dir_rows.push_back(row);
    endtask

    // Present one request from the next falling edge until the block takes it,
    // then book the results it owes (hand-typed ones for typed rows).
    task automatic offer(input t_req r, input bit typed, input bit has_res,
                         input t_packed res);
        int j;
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_command     <= r.cmd;
        i_symbol      <= r.sym;
        i_code_bits   <= r.bits;
        i_code_length <= r.len;
        @(posedge i_clk);
        while (o_stall !== 1'b0)
            @(posedge i_clk);
        n_taken++;
        advance_packer(r);
        if (typed) begin
            if (has_res)
                packed_due.push_back(res);
        end else begin
            for (j = 0; j < packed_new.size(); j++)
                packed_due.push_back(packed_new[j]);
        end
    endtask

    // Sender gap: valid low, payload scrambled since nobody may look at it.
    task automatic rest(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_valid       <= 1'b0;
            i_command     <= 2'($urandom);
            i_symbol      <= hsbp_pkg::SYM_W'($urandom);
            i_code_bits   <= $urandom;
            i_code_length <= hsbp_pkg::LEN_W'($urandom);
        end
    endtask

    // Sender pause until the block has paid out everything it owes.
    task automatic drain();
        rest(1);
        while (packed_due.size() != 0)
            @(posedge i_clk);
    endtask

    // Receiver: random stall phases (none, light, heavy, coin flip); once,
    // a long hold while the sender keeps pushing, so the queue fills and
    // the block has to stall its input.
    initial begin
        i_stall    = 1'b0;
        held_off   = 1'b0;
        phase_left = 0;
        stall_mode = 0;
        forever begin
            @(negedge i_clk);
            if (!held_off && n_taken >= HOLD_AFTER) begin
                held_off = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                if (phase_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    phase_left = $urandom_range(10, 60);
                end
                phase_left--;
                case (stall_mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    2: i_stall <= ($urandom_range(0, 3) != 0);
                    default: i_stall <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    // Output check: every transfer is matched against the oldest owed result.
    always @(posedge i_clk) begin : check_out
        t_packed want;
        if (i_rst_n === 1'b1 && o_valid !== 1'b0 && i_stall == 1'b0) begin
            if (packed_due.size() == 0) begin
                flag_mismatch("result with nothing owed", o_packed_data, '0);
            end else begin
                want = packed_due.pop_front();
                if (o_valid !== 1'b1)
                    flag_mismatch("valid", {31'd0, o_valid}, 32'd1);
                if (o_packed_data !== want.data)
                    flag_mismatch("packed_data", o_packed_data, want.data);
                if (o_is_byte !== want.is_byte)
                    flag_mismatch("is_byte", {31'd0, o_is_byte}, {31'd0, want.is_byte});
                if (o_last !== want.last)
                    flag_mismatch("last", {31'd0, o_last}, {31'd0, want.last});
                if (o_tail_bits !== want.tail)
                    flag_mismatch("tail_bits", {29'd0, o_tail_bits}, {29'd0, want.tail});
            end
        end
    end

    // Watchdog: ends the run when neither channel moves for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid === 1'b1 && o_stall === 1'b0) || (o_valid === 1'b1 && i_stall === 1'b0))
                quiet = 0;
            else
                quiet++;
        end
        $display("[huffman_symbol_bit_packer] ERROR");
        $finish;
    end

    initial begin : stimulus
        t_req r;
        int   k;
        int   pick;
        int   burst_left;

        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_command     = hsbp_pkg::CMD_LOAD;
        i_symbol      = '0;
        i_code_bits   = '0;
        i_code_length = '0;
        mismatch_cnt  = 0;
        n_taken       = 0;
        bitbuf        = '0;
        held          = 0;
        for (k = 0; k < SYM_COUNT; k++) begin
            code_mem[k] = '0;
            len_mem[k]  = '0;
        end

        // Directed part. Table starts empty after reset.
        add_row(hsbp_pkg::CMD_ENCODE, 7,   32'h0, 0, 1);          // never loaded: nothing
        add_row(hsbp_pkg::CMD_FLUSH,  0,   32'h0, 0, 1);          // flush with nothing held
        add_row(CMD_UNUSED,           255, 32'hFFFF_FFFF, 63, 1); // unknown command
        add_row(hsbp_pkg::CMD_LOAD,   255, 32'hFFFF_FFFF, 63, 1); // length saturates to 32
        add_row(hsbp_pkg::CMD_LOAD,   0,   32'hFFFF_FFFF, 3, 1);  // stray bits cleared
        add_row(hsbp_pkg::CMD_LOAD,   1,   32'hA5A5_A5A5, 32, 1);
        add_row(hsbp_pkg::CMD_LOAD,   2,   32'hFFFF_FFFF, 0, 1);  // zero-length code
        add_row(hsbp_pkg::CMD_LOAD,   3,   32'h0000_015A, 8, 1);  // bit 8 dropped -> 8'h5A
        add_row(hsbp_pkg::CMD_ENCODE, 0,   32'h0, 0, 1);
        add_row(hsbp_pkg::CMD_FLUSH,  0,   32'h0, 0, 1, 1, 32'h07, 1, 3);
        add_row(hsbp_pkg::CMD_ENCODE, 255, 32'h0, 0, 1);          // exactly 32 held: no word
        add_row(hsbp_pkg::CMD_ENCODE, 2,   32'h0, 0, 1);          // zero-length encode
        add_row(hsbp_pkg::CMD_FLUSH,  0,   32'h0, 0);             // four 0xFF bytes
        add_row(hsbp_pkg::CMD_ENCODE, 255, 32'h0, 0, 1);
        add_row(hsbp_pkg::CMD_ENCODE, 0,   32'h0, 0, 1, 1, 32'hFFFF_FFFF, 0, 0, 0);
        add_row(hsbp_pkg::CMD_FLUSH,  0,   32'h0, 0, 1, 1, 32'h07, 1, 3);
        add_row(hsbp_pkg::CMD_ENCODE, 1,   32'h0, 0);
        add_row(hsbp_pkg::CMD_ENCODE, 1,   32'h0, 0, 1, 1, 32'hA5A5_A5A5, 0, 0, 0);
        add_row(hsbp_pkg::CMD_ENCODE, 3,   32'h0, 0, 1, 1, 32'hA5A5_A5A5, 0, 0, 0);
        add_row(hsbp_pkg::CMD_FLUSH,  0,   32'h0, 0, 1, 1, 32'h5A, 1, 0);
        add_row(hsbp_pkg::CMD_LOAD,   4,   32'hFFFF_FFFE, 1, 1);  // one-bit code 0
        add_row(hsbp_pkg::CMD_ENCODE, 4,   32'h0, 0);
        add_row(hsbp_pkg::CMD_ENCODE, 3,   32'h0, 0);
        add_row(hsbp_pkg::CMD_FLUSH,  0,   32'h0, 0);             // 9 bits: tail 1
        add_row(hsbp_pkg::CMD_LOAD,   5,   32'h8000_0001, 32);
        add_row(hsbp_pkg::CMD_ENCODE, 5,   32'h0, 0);
        add_row(hsbp_pkg::CMD_FLUSH,  0,   32'h0, 0);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            offer(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].has_res, dir_rows[k].res);
            rest($urandom_range(0, 2));
        end
        drain();

        // Random part: mostly encodes of a small hot symbol set, loads with
        // lengths across the range, occasional flushes and some noise.
        burst_left = 0;
        for (k = 0; k < RAND_ITEMS; k++) begin
            r.cmd  = 2'($urandom);
            r.sym  = hsbp_pkg::SYM_W'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 15)
                                                                   : $urandom_range(0, 255));
            r.bits = $urandom;
            r.len  = hsbp_pkg::LEN_W'($urandom);
            pick   = $urandom_range(0, 99);
            if (pick < 18) begin
                r.cmd = hsbp_pkg::CMD_LOAD;
                pick  = $urandom_range(0, 99);
                if (pick < 75)
                    r.len = hsbp_pkg::LEN_W'($urandom_range(1, 32));
                else if (pick < 85)
                    r.len = '0;
                else
                    r.len = hsbp_pkg::LEN_W'($urandom_range(33, 63));
            end else if (pick < 82) begin
                r.cmd = hsbp_pkg::CMD_ENCODE;
            end else if (pick < 94) begin
                r.cmd = hsbp_pkg::CMD_FLUSH;
            end else begin
                r.cmd = CMD_UNUSED;
            end

            offer(r, 1'b0, 1'b0, '0);

            if (k == DRAIN_AT)
                drain();

            // bursts of random length; a zero gap keeps valid high
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 20);
                rest(($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6));
            end else begin
                burst_left--;
            end
        end

        drain();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("[huffman_symbol_bit_packer] OK");
        else
            $display("[huffman_symbol_bit_packer] ERROR");
        $finish;
    end

endmodule
